// ===== src/pkrle_pkg.sv =====
// Package with the constants and types shared by the run-length pixel encoder.
`timescale 1ns / 1ps
package pkrle_pkg;

  localparam int unsigned ColorW = 11;
  localparam int unsigned LenW   = 11;
  localparam int unsigned HalfW  = 12;
  localparam int unsigned WordW  = 2 * HalfW;
  localparam int unsigned MaxWords = 3;
  localparam int unsigned CntW   = 2;

  localparam logic [LenW-1:0] RunCap = 11'd2046;
  localparam logic [LenW-1:0] OneLen = 11'd1;

  // Encoder state carried from one pixel to the next.
  typedef struct packed {
    logic              seen;
    logic [ColorW-1:0] run_color;
    logic [LenW-1:0]   run_len;
    logic              single_pending;
    logic [ColorW-1:0] pend_color;
  } pkrle_state_t;

  // Words caused by one pixel, oldest in slot zero.
  typedef struct packed {
    logic [MaxWords-1:0][WordW-1:0] words;
    logic [CntW-1:0]                cnt;
    logic                           eoi;
  } pkrle_bundle_t;

  function automatic logic [WordW-1:0] run_word(logic [ColorW-1:0] color,
                                                logic [LenW-1:0] len);
    return {1'b0, color, 1'b0, len};
  endfunction

  function automatic logic [WordW-1:0] pair_word(logic [ColorW-1:0] first,
                                                 logic [ColorW-1:0] second);
    return {1'b1, first, 1'b1, second};
  endfunction

endpackage

// ===== src/pkrle_enc.sv =====
// Next-state and output-word logic for one pixel of the run-length encoder.
`timescale 1ns / 1ps
module pkrle_enc (
  input  pkrle_pkg::pkrle_state_t  state_i,
  input  logic [10:0]              pixel_color_i,
  input  logic                     last_pixel_i,
  output pkrle_pkg::pkrle_state_t  state_o,
  output pkrle_pkg::pkrle_bundle_t bundle_o
);
  import pkrle_pkg::*;

  pkrle_state_t  st;
  pkrle_bundle_t bd;

  always_comb begin
    st       = state_i;
    bd.words = '0;
    bd.cnt   = '0;
    bd.eoi   = last_pixel_i;

    if (!state_i.seen) begin
      st.seen      = 1'b1;
      st.run_color = pixel_color_i;
      st.run_len   = OneLen;
    end else if (pixel_color_i == state_i.run_color && state_i.run_len < RunCap) begin
      st.run_len = state_i.run_len + OneLen;
    end else begin
      if (state_i.run_len == OneLen) begin
        if (!state_i.single_pending) begin
          st.single_pending = 1'b1;
          st.pend_color     = state_i.run_color;
        end else begin
          bd.words[bd.cnt]  = pair_word(state_i.pend_color, state_i.run_color);
          bd.cnt            = bd.cnt + 2'd1;
          st.single_pending = 1'b0;
        end
      end else begin
        if (state_i.single_pending) begin
          bd.words[bd.cnt]  = run_word(state_i.pend_color, OneLen);
          bd.cnt            = bd.cnt + 2'd1;
          st.single_pending = 1'b0;
        end
        bd.words[bd.cnt] = run_word(state_i.run_color, state_i.run_len);
        bd.cnt           = bd.cnt + 2'd1;
      end
      st.run_color = pixel_color_i;
      st.run_len   = OneLen;
    end

    // End of image flushes the waiting single and the open run.
    if (last_pixel_i) begin
      if (st.single_pending) begin
        bd.words[bd.cnt] = run_word(st.pend_color, OneLen);
        bd.cnt           = bd.cnt + 2'd1;
      end
      bd.words[bd.cnt] = run_word(st.run_color, st.run_len);
      bd.cnt           = bd.cnt + 2'd1;
      st               = '0;
    end
  end

  assign state_o  = st;
  assign bundle_o = bd;

endmodule

// ===== src/packed_run_length_pixel_encoder_top.sv =====
// Top level of the packed run-length pixel encoder.
//
//   channel  direction  handshake               payload
//   input    in         in_valid_i, in_stall_o  pixel_color_i[10:0], last_pixel_i
//   output   out        out_valid_o, out_stall_i packed_word_o[23:0], last_of_item_o,
//                                               end_of_image_o
//
// One pixel is accepted per cycle while each pixel causes at most one word and the output does not stall.
// A pixel that causes more than one word holds the input while the single output
// register drains the word bundle one word per cycle when the output does not stall.
// A word passes from its pixel's transaction through the bundle register and then the output register.
// Reset clears the run state, the bundle and the output register.
// An output stall holds the output word and, while the bundle holds any word, the input.
`timescale 1ns / 1ps
module packed_run_length_pixel_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [10:0] pixel_color_i,
  input  logic        last_pixel_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] packed_word_o,
  output logic        last_of_item_o,
  output logic        end_of_image_o
);
  import pkrle_pkg::*;

  pkrle_state_t  state_q, state_d;
  pkrle_bundle_t enc_bundle;
  pkrle_bundle_t bundle_q, bundle_d;

  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_word_q, out_word_d;
  logic             out_last_q, out_last_d;
  logic             out_eoi_q, out_eoi_d;

  logic o_load;
  logic move;
  logic in_accept;

  pkrle_enc u_enc (
    .state_i       (state_q),
    .pixel_color_i (pixel_color_i),
    .last_pixel_i  (last_pixel_i),
    .state_o       (state_d),
    .bundle_o      (enc_bundle)
  );

  assign o_load     = !out_valid_q || !out_stall_i;
  assign move       = o_load && (bundle_q.cnt != '0);
  assign in_stall_o = !((bundle_q.cnt == '0) || (bundle_q.cnt == 2'd1 && o_load));
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    bundle_d    = bundle_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    out_eoi_d   = out_eoi_q;

    if (o_load) begin
      out_valid_d = move;
      out_word_d  = bundle_q.words[0];
      out_last_d  = (bundle_q.cnt == 2'd1);
      out_eoi_d   = (bundle_q.cnt == 2'd1) && bundle_q.eoi;
    end

    if (in_accept) begin
      bundle_d = enc_bundle;
    end else if (move) begin
      bundle_d.words = {{WordW{1'b0}}, bundle_q.words[MaxWords-1:1]};
      bundle_d.cnt   = bundle_q.cnt - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      bundle_q    <= '0;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
      out_last_q  <= 1'b0;
      out_eoi_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      bundle_q    <= bundle_d;
      out_valid_q <= out_valid_d;
      out_word_q  <= out_word_d;
      out_last_q  <= out_last_d;
      out_eoi_q   <= out_eoi_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_word_o  = out_word_q;
  assign last_of_item_o = out_last_q;
  assign end_of_image_o = out_eoi_q;

`ifndef SYNTHESIS
  // An open run never grows past the cap.
  a_run_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.run_len <= RunCap)
    else $error("run length exceeds cap");

  // Without an open run there is neither a length nor a waiting single.
  a_idle_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.seen |-> (state_q.run_len == '0 && !state_q.single_pending))
    else $error("state held without an open run");

  // The final pixel of an image leaves the encoder in its reset state.
  a_image_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_pixel_i) |=> (!state_q.seen && bundle_q.eoi))
    else $error("image end did not clear the run state");
`endif

endmodule

// ===== sim/tb_packed_run_length_pixel_encoder_top.sv =====
// Testbench for the packed run-length pixel encoder, checked against a predictor.
`timescale 1ns / 1ps
module tb_packed_run_length_pixel_encoder_top;

  localparam int unsigned CycleLimit = 400000;
  localparam logic [11:0] PairFlag = 12'd2048;
  localparam logic [11:0] LenOne   = 12'd1;
  localparam logic [10:0] ColorMax = 11'd2047;

  typedef struct packed {
    logic [23:0] word;
    logic        last_of_item;
    logic        end_of_image;
  } exp_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [10:0] pixel_color_i;
  logic        last_pixel_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [23:0] packed_word_o;
  logic        last_of_item_o;
  logic        end_of_image_o;

  // Encoder state as the predictor sees it.
  logic        run_open;
  logic [10:0] run_color;
  logic [10:0] run_len;
  logic        single_waiting;
  logic [10:0] waiting_color;

  exp_word_t   expected_words[$];
  int unsigned error_count;
  logic        quiet;
  logic [10:0] prev_color;

  packed_run_length_pixel_encoder_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_color_i  (pixel_color_i),
    .last_pixel_i   (last_pixel_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_word_o  (packed_word_o),
    .last_of_item_o (last_of_item_o),
    .end_of_image_o (end_of_image_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void push_word(logic [11:0] hi, logic [11:0] lo);
    exp_word_t w;
    w.word = {hi, lo};
    w.last_of_item = 1'b0;
    w.end_of_image = 1'b0;
    expected_words.push_back(w);
  endfunction

  // Updates the predicted encoder state with one accepted pixel and queues its words.
  function automatic void encode_pixel(logic [10:0] color, logic last);
    int unsigned before_cnt;
    exp_word_t   w;
    before_cnt = expected_words.size();
    if (!run_open) begin
      run_open = 1'b1;
      run_color = color;
      run_len = 11'd1;
    end else if (color == run_color && run_len < pkrle_pkg::RunCap) begin
      run_len = run_len + 11'd1;
    end else begin
      if (run_len == 11'd1) begin
        if (!single_waiting) begin
          single_waiting = 1'b1;
          waiting_color = run_color;
        end else begin
          push_word(PairFlag + 12'(waiting_color), PairFlag + 12'(run_color));
          single_waiting = 1'b0;
        end
      end else begin
        if (single_waiting) begin
          push_word(12'(waiting_color), LenOne);
          single_waiting = 1'b0;
        end
        push_word(12'(run_color), 12'(run_len));
      end
      run_color = color;
      run_len = 11'd1;
    end
    if (last) begin
      if (single_waiting) push_word(12'(waiting_color), LenOne);
      push_word(12'(run_color), 12'(run_len));
      w = expected_words.pop_back();
      w.end_of_image = 1'b1;
      expected_words.push_back(w);
      run_open = 1'b0;
      run_color = '0;
      run_len = '0;
      single_waiting = 1'b0;
      waiting_color = '0;
    end
    if (expected_words.size() > before_cnt) begin
      w = expected_words.pop_back();
      w.last_of_item = 1'b1;
      expected_words.push_back(w);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Entered and left at a rising edge; the pixel is predicted once its transaction is done.
  task automatic send_pixel(input logic [10:0] color, input logic last);
    int   gap;
    logic taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_color_i <= color;
    last_pixel_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    encode_pixel(color, last);
    prev_color = color;
  endtask

  function automatic logic [10:0] pick_color();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return prev_color;
    if (r < 15) return '0;
    if (r < 20) return ColorMax;
    if (r < 30) return 11'($urandom_range(0, 3));
    return 11'($urandom_range(0, 2047));
  endfunction

  // Output side: stall bursts, mostly short and a few long.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (!quiet && $urandom_range(0, 99) < 20) begin
          stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  // Every output transaction is compared with the oldest predicted word.
  initial begin
    exp_word_t w;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word %h with no prediction waiting", packed_word_o);
          error_count++;
        end else begin
          w = expected_words.pop_front();
          if (packed_word_o !== w.word) begin
            $error("packed_word: expected %h, actual %h", w.word, packed_word_o);
            error_count++;
          end
          if (last_of_item_o !== w.last_of_item) begin
            $error("last_of_item: expected %b, actual %b", w.last_of_item, last_of_item_o);
            error_count++;
          end
          if (end_of_image_o !== w.end_of_image) begin
            $error("end_of_image: expected %b, actual %b", w.end_of_image, end_of_image_o);
            error_count++;
          end
        end
      end
    end
  end

  task automatic test_single_pixel_images();
    send_pixel('0, 1'b1);
    send_pixel(ColorMax, 1'b1);
    send_pixel(11'h555, 1'b1);
  endtask

  // Lone one-pixel runs pair up; an odd one left at the end is flushed as a run.
  task automatic test_pairs_and_flush();
    send_pixel(11'd5, 1'b0);
    send_pixel(11'd6, 1'b0);
    send_pixel(11'd7, 1'b0);
    send_pixel(ColorMax, 1'b0);
    send_pixel('0, 1'b1);
    send_pixel(11'd5, 1'b0);
    send_pixel(11'd6, 1'b0);
    send_pixel(11'd7, 1'b1);
  endtask

  // A waiting single is written out ahead of a longer run, giving three words on one pixel.
  task automatic test_single_before_run();
    send_pixel(11'd3, 1'b0);
    send_pixel(11'h2aa, 1'b0);
    send_pixel(11'h2aa, 1'b0);
    send_pixel(11'h2aa, 1'b0);
    send_pixel(11'd9, 1'b1);
    send_pixel(ColorMax, 1'b0);
    send_pixel(ColorMax, 1'b1);
  endtask

  task automatic test_random_images(input int n_items);
    int          sent;
    int          img_len;
    int          run_cnt;
    int          idx;
    int          r;
    logic [10:0] color;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 9);
      img_len = (r < 2) ? 1 : (r < 8) ? $urandom_range(2, 20) : $urandom_range(21, 60);
      idx = 0;
      while (idx < img_len) begin
        color = pick_color();
        r = $urandom_range(0, 9);
        run_cnt = (r < 5) ? 1 : (r < 8) ? $urandom_range(2, 4) : $urandom_range(5, 12);
        while (run_cnt > 0 && idx < img_len) begin
          send_pixel(color, idx == img_len - 1);
          idx++;
          run_cnt--;
        end
      end
      sent += img_len;
    end
  endtask

  initial begin
    error_count = 0;
    quiet = 1'b0;
    prev_color = '0;
    run_open = 1'b0;
    run_color = '0;
    run_len = '0;
    single_waiting = 1'b0;
    waiting_color = '0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    pixel_color_i <= '0;
    last_pixel_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_pixel_images();
    test_pairs_and_flush();
    test_single_before_run();
    test_random_images(90);
    quiet = 1'b1;
    test_random_images(60);
    quiet = 1'b0;
    test_random_images(90);

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
